// ===== hw/rtl/sbia_pkg.sv =====
`timescale 1ns / 1ps

package sbia_pkg;

  // adc sample width, fixed by the sample ports
  localparam int ADC_BITS = 12;
  localparam int CNT_W    = 16;

  // register map, index = paddr / 4
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_AUTO_MODE_MAX    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ON_MODE_MAX      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DUSK_THRESH      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DAY_THRESH       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DUSK_DELAY_TICKS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DAY_DELAY_TICKS  = 3'd5;

  localparam logic [ADC_BITS-1:0] RST_AUTO_MODE_MAX    = 12'd1351;
  localparam logic [ADC_BITS-1:0] RST_ON_MODE_MAX      = 12'd2703;
  localparam logic [ADC_BITS-1:0] RST_DUSK_THRESH      = 12'd2048;
  localparam logic [ADC_BITS-1:0] RST_DAY_THRESH       = 12'd3276;
  localparam logic [CNT_W-1:0]    RST_DUSK_DELAY_TICKS = 16'd100;
  localparam logic [CNT_W-1:0]    RST_DAY_DELAY_TICKS  = 16'd200;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_RUN   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] auto_mode_max;
    logic [ADC_BITS-1:0] on_mode_max;
    logic [ADC_BITS-1:0] dusk_thresh;
    logic [ADC_BITS-1:0] day_thresh;
    logic [CNT_W-1:0]    dusk_delay_ticks;
    logic [CNT_W-1:0]    day_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic ignition_ready;
    logic engine_lamp;
    logic buzzer_on;
    logic welcome_pulse;
    logic inhibit_report;
    logic driver_seat_missing;
    logic passenger_seat_missing;
    logic driver_belt_missing;
    logic passenger_belt_missing;
    logic started_pulse;
    logic stopped_pulse;
  } ign_res_t;

endpackage

// ===== hw/rtl/sbia_ignition.sv =====
`timescale 1ns / 1ps

module sbia_ignition (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              driver_seated,
  input  logic              passenger_seated,
  input  logic              driver_belted,
  input  logic              passenger_belted,
  input  logic              start_button,
  output sbia_pkg::ign_res_t res
);
  import sbia_pkg::*;

  phase_t phase_r, phase_nxt, ph_eff;
  logic   ready_r, ready_nxt;
  logic   engine_r, engine_nxt;
  logic   buzzer_r, buzzer_nxt;
  logic   bwp_r, bwp_nxt;
  logic   reported_r, reported_nxt;
  logic   greeted_r, greeted_nxt;
  logic   all_set;

  assign all_set = driver_seated & passenger_seated & driver_belted & passenger_belted;
  // unused phase code behaves as idle
  assign ph_eff  = (phase_r == PH_ARMED || phase_r == PH_RUN) ? phase_r : PH_IDLE;

  // next phase
  always_comb begin
    unique case (ph_eff)
      PH_IDLE:  phase_nxt = (start_button && all_set) ? PH_ARMED : PH_IDLE;
      PH_ARMED: phase_nxt = PH_RUN;
      PH_RUN:   phase_nxt = (!start_button && bwp_r) ? PH_IDLE : PH_RUN;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  // lamps, pulses and flags
  always_comb begin
    res          = '0;
    greeted_nxt  = greeted_r | driver_seated;
    ready_nxt    = (ph_eff != PH_RUN) ? all_set : ready_r;
    engine_nxt   = engine_r;
    buzzer_nxt   = buzzer_r;
    bwp_nxt      = bwp_r;
    reported_nxt = reported_r;
    res.welcome_pulse = driver_seated & ~greeted_r;
    unique case (ph_eff)
      PH_IDLE: begin
        if (start_button && !all_set) begin
          buzzer_nxt = 1'b1;
          if (!reported_r) begin
            reported_nxt               = 1'b1;
            res.inhibit_report         = 1'b1;
            res.driver_seat_missing    = ~driver_seated;
            res.passenger_seat_missing = ~passenger_seated;
            res.driver_belt_missing    = ~driver_belted;
            res.passenger_belt_missing = ~passenger_belted;
          end
        end
      end
      PH_ARMED: begin
        ready_nxt         = 1'b0;
        engine_nxt        = 1'b1;
        buzzer_nxt        = 1'b0;
        bwp_nxt           = 1'b0;
        res.started_pulse = 1'b1;
      end
      PH_RUN: begin
        if (start_button) begin
          bwp_nxt = 1'b1;
        end else if (bwp_r) begin
          bwp_nxt           = 1'b0;
          engine_nxt        = 1'b0;
          res.stopped_pulse = 1'b1;
        end
      end
      default: ;
    endcase
    res.ignition_ready = ready_nxt;
    res.engine_lamp    = engine_nxt;
    res.buzzer_on      = buzzer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      ready_r    <= 1'b0;
      engine_r   <= 1'b0;
      buzzer_r   <= 1'b0;
      bwp_r      <= 1'b0;
      reported_r <= 1'b0;
      greeted_r  <= 1'b0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      ready_r    <= ready_nxt;
      engine_r   <= engine_nxt;
      buzzer_r   <= buzzer_nxt;
      bwp_r      <= bwp_nxt;
      reported_r <= reported_nxt;
      greeted_r  <= greeted_nxt;
    end
  end

endmodule

// ===== hw/rtl/sbia_headlight.sv =====
`timescale 1ns / 1ps

module sbia_headlight #(
  parameter int AVG_SAMPLES = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          engine_run,
  input  logic [sbia_pkg::ADC_BITS-1:0] mode_sample,
  input  logic [sbia_pkg::ADC_BITS-1:0] light_sample,
  input  sbia_pkg::cfg_t                cfg,
  output logic                          lights_on
);
  import sbia_pkg::*;

  localparam int SUM_W = ADC_BITS + $clog2(AVG_SAMPLES);
  localparam int IDX_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam logic [SUM_W-1:0] AVG_N    = SUM_W'(AVG_SAMPLES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_SAMPLES - 1);

  logic [ADC_BITS-1:0] win_r [AVG_SAMPLES];
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    dark_r, dark_nxt, dark_inc;
  logic [CNT_W-1:0]    bright_r, bright_nxt, bright_inc;
  logic                lights_r, lights_nxt;
  logic [SUM_W-1:0]    dusk_th, day_th;
  logic                auto_sel, win_we;

  assign dusk_th    = SUM_W'(cfg.dusk_thresh) * AVG_N;
  assign day_th     = SUM_W'(cfg.day_thresh) * AVG_N;
  assign auto_sel   = engine_run && (mode_sample <= cfg.auto_mode_max);
  assign win_we     = adv && auto_sel;
  assign sum_nxt    = sum_r - SUM_W'(win_r[idx_r]) + SUM_W'(light_sample);
  assign idx_nxt    = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
  assign dark_inc   = (dark_r == '1) ? dark_r : dark_r + CNT_W'(1);
  assign bright_inc = (bright_r == '1) ? bright_r : bright_r + CNT_W'(1);

  always_comb begin
    dark_nxt   = dark_r;
    bright_nxt = bright_r;
    lights_nxt = 1'b0;
    if (auto_sel) begin
      lights_nxt = lights_r;
      if (sum_nxt <= dusk_th) begin
        dark_nxt = dark_inc;
        if (dark_inc >= cfg.dusk_delay_ticks) begin
          dark_nxt   = '0;
          bright_nxt = '0;
          lights_nxt = 1'b1;
        end
      end else if (sum_nxt <= day_th) begin
        dark_nxt   = '0;
        bright_nxt = '0;
      end else begin
        bright_nxt = bright_inc;
        if (bright_inc >= cfg.day_delay_ticks) begin
          dark_nxt   = '0;
          bright_nxt = '0;
          lights_nxt = 1'b0;
        end
      end
    end else if (engine_run) begin
      lights_nxt = (mode_sample <= cfg.on_mode_max);
    end
  end

  assign lights_on = lights_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lights_r <= 1'b0;
      dark_r   <= '0;
      bright_r <= '0;
      idx_r    <= '0;
      sum_r    <= '0;
    end else if (adv) begin
      lights_r <= lights_nxt;
      dark_r   <= dark_nxt;
      bright_r <= bright_nxt;
      if (auto_sel) begin
        idx_r <= idx_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  // averaging window, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_SAMPLES; i++) begin
        win_r[i] <= '0;
      end
    end else if (win_we) begin
      win_r[idx_r] <= light_sample;
    end
  end

endmodule

// ===== hw/rtl/seatbelt_ignition_and_auto_headlight_top.sv =====
`timescale 1ns / 1ps

// Seatbelt-interlocked ignition with automatic headlights. Each input
// transaction is one tick of seat, belt and start-button levels plus the mode
// potentiometer and ambient light samples; each tick returns exactly one
// result transaction with the lamp levels after the tick and the one-tick
// welcome, inhibit-report and start/stop pulses. A tick is captured in an
// input register, all of its work is done in one pass of short logic, and
// the result lands in an output register, so the block takes one transaction
// per clock while results are taken, each via the input and output registers.
// in_ready drops only while the output register holds a result that the
// consumer has not taken. Headlight thresholds and hysteresis delays sit in
// an APB register file (byte address 4*i, registers in the order auto mode
// max, on mode max, dusk level, day level, dusk delay, day delay); write
// them only while the block is idle. AVG_SAMPLES sets the depth of the light
// averaging window; the window is cleared by reset, so no clearing pass runs.
module seatbelt_ignition_and_auto_headlight_top #(
  parameter int AVG_SAMPLES = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_driver_seated,
  input  logic                          in_passenger_seated,
  input  logic                          in_driver_belted,
  input  logic                          in_passenger_belted,
  input  logic                          in_start_button,
  input  logic [sbia_pkg::ADC_BITS-1:0] in_mode_sample,
  input  logic [sbia_pkg::ADC_BITS-1:0] in_light_sample,
  // result transaction
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ignition_ready,
  output logic                          out_engine_lamp,
  output logic                          out_buzzer_on,
  output logic                          out_headlights_on,
  output logic                          out_welcome_pulse,
  output logic                          out_inhibit_report,
  output logic                          out_driver_seat_missing,
  output logic                          out_passenger_seat_missing,
  output logic                          out_driver_belt_missing,
  output logic                          out_passenger_belt_missing,
  output logic                          out_started_pulse,
  output logic                          out_stopped_pulse,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sbia_pkg::*;

  typedef struct packed {
    logic                driver_seated;
    logic                passenger_seated;
    logic                driver_belted;
    logic                passenger_belted;
    logic                start_button;
    logic [ADC_BITS-1:0] mode_sample;
    logic [ADC_BITS-1:0] light_sample;
  } in_item_t;

  cfg_t             cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic             reg_we;

  in_item_t         s1_r;
  logic             s1_valid_r;
  logic             s1_adv;

  ign_res_t         ign_res;
  logic             lights_on;

  ign_res_t         res_r;
  logic             lights_r;
  logic             out_valid_r, out_valid_nxt;

  // ---------------------------------------------------------------------------
  // register file, zero-wait APB
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_we  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_mode_max    <= RST_AUTO_MODE_MAX;
      cfg_r.on_mode_max      <= RST_ON_MODE_MAX;
      cfg_r.dusk_thresh      <= RST_DUSK_THRESH;
      cfg_r.day_thresh       <= RST_DAY_THRESH;
      cfg_r.dusk_delay_ticks <= RST_DUSK_DELAY_TICKS;
      cfg_r.day_delay_ticks  <= RST_DAY_DELAY_TICKS;
    end else if (reg_we) begin
      unique case (reg_idx)
        REG_AUTO_MODE_MAX:    cfg_r.auto_mode_max    <= pwdata[ADC_BITS-1:0];
        REG_ON_MODE_MAX:      cfg_r.on_mode_max      <= pwdata[ADC_BITS-1:0];
        REG_DUSK_THRESH:      cfg_r.dusk_thresh      <= pwdata[ADC_BITS-1:0];
        REG_DAY_THRESH:       cfg_r.day_thresh       <= pwdata[ADC_BITS-1:0];
        REG_DUSK_DELAY_TICKS: cfg_r.dusk_delay_ticks <= pwdata[CNT_W-1:0];
        REG_DAY_DELAY_TICKS:  cfg_r.day_delay_ticks  <= pwdata[CNT_W-1:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_AUTO_MODE_MAX:    prdata = 32'(cfg_r.auto_mode_max);
      REG_ON_MODE_MAX:      prdata = 32'(cfg_r.on_mode_max);
      REG_DUSK_THRESH:      prdata = 32'(cfg_r.dusk_thresh);
      REG_DAY_THRESH:       prdata = 32'(cfg_r.day_thresh);
      REG_DUSK_DELAY_TICKS: prdata = 32'(cfg_r.dusk_delay_ticks);
      REG_DAY_DELAY_TICKS:  prdata = 32'(cfg_r.day_delay_ticks);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input register; the tick is processed when the output register can take it
  // ---------------------------------------------------------------------------
  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r.driver_seated    <= in_driver_seated;
      s1_r.passenger_seated <= in_passenger_seated;
      s1_r.driver_belted    <= in_driver_belted;
      s1_r.passenger_belted <= in_passenger_belted;
      s1_r.start_button     <= in_start_button;
      s1_r.mode_sample      <= in_mode_sample;
      s1_r.light_sample     <= in_light_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // single pass: ignition sequence, then headlights from the new engine state
  // ---------------------------------------------------------------------------
  sbia_ignition u_ignition (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (s1_adv),
    .driver_seated    (s1_r.driver_seated),
    .passenger_seated (s1_r.passenger_seated),
    .driver_belted    (s1_r.driver_belted),
    .passenger_belted (s1_r.passenger_belted),
    .start_button     (s1_r.start_button),
    .res              (ign_res)
  );

  sbia_headlight #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_headlight (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (s1_adv),
    .engine_run   (ign_res.engine_lamp),
    .mode_sample  (s1_r.mode_sample),
    .light_sample (s1_r.light_sample),
    .cfg          (cfg_r),
    .lights_on    (lights_on)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r    <= ign_res;
      lights_r <= lights_on;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_ignition_ready         = res_r.ignition_ready;
  assign out_engine_lamp            = res_r.engine_lamp;
  assign out_buzzer_on              = res_r.buzzer_on;
  assign out_headlights_on          = lights_r;
  assign out_welcome_pulse          = res_r.welcome_pulse;
  assign out_inhibit_report         = res_r.inhibit_report;
  assign out_driver_seat_missing    = res_r.driver_seat_missing;
  assign out_passenger_seat_missing = res_r.passenger_seat_missing;
  assign out_driver_belt_missing    = res_r.driver_belt_missing;
  assign out_passenger_belt_missing = res_r.passenger_belt_missing;
  assign out_started_pulse          = res_r.started_pulse;
  assign out_stopped_pulse          = res_r.stopped_pulse;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // start and stop never land on the same tick
  a_start_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.started_pulse && res_r.stopped_pulse))
    else $error("start and stop pulses in one result");

  // reason flags only travel with the report
  a_reasons_with_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.inhibit_report) |->
      !(res_r.driver_seat_missing || res_r.passenger_seat_missing ||
        res_r.driver_belt_missing || res_r.passenger_belt_missing))
    else $error("reason flag without inhibit report");

  // headlights are dark whenever the engine is off
  a_lights_need_engine: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && lights_r) |-> res_r.engine_lamp)
    else $error("headlights on with engine off");

  // ready lamp is dark while the engine runs
  a_ready_dark_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.engine_lamp) |-> !res_r.ignition_ready)
    else $error("ready lamp lit with engine running");

  // a stalled result is not overwritten
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_r) && $stable(lights_r)))
    else $error("pending result changed");

endmodule
